FILE: hw/rtl/biquad_cascade_filter_macros.svh
// Assertion macros shared by the biquad cascade checker
`ifndef BIQUAD_CASCADE_FILTER_MACROS_SVH
`define BIQUAD_CASCADE_FILTER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent
`define BQC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("biquad_cascade_filter: assertion failed");

// Consequent must hold in the same cycle as the antecedent
`define BQC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("biquad_cascade_filter: assertion failed");

`endif

FILE: hw/rtl/bqc_pkg.sv
// Shared constants, control word types and microcode table of the biquad cascade
`default_nettype none

package bqc_pkg;

    localparam int MAX_STAGES_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 16;
    localparam int COEFS_PER_STAGE = 5;
    localparam int STATE_BITS      = 32;
    localparam int STAGES_W        = 4;
    localparam int CFG_ADDR_W      = 1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_STAGES = 1'b1;

    localparam logic [STAGES_W-1:0] STAGES_RESET = 4'd1;

    // Item kinds carried on tuser
    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    // Coefficient slot within a stage
    typedef enum logic [2:0] {K_B0, K_B1, K_B2, K_A1, K_A2} coef_sel_t;

    // Multiplier operand selection
    typedef enum logic [1:0] {MUL_NONE, MUL_GAIN_X, MUL_COEF_X, MUL_COEF_Y} mul_op_t;

    // Accumulator operation on the registered product
    typedef enum logic [2:0] {ACC_NOP, ACC_LD_D1, ACC_LD_D2, ACC_LD, ACC_SUB} acc_op_t;

    // Register write-back from the accumulator
    typedef enum logic [2:0] {WR_NONE, WR_X, WR_Y, WR_D1, WR_D2} wr_op_t;

    // Sequencing: advance, skip stages when none active, stage loop, finish
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_SKIP_IF_EMPTY, SEQ_LOOP, SEQ_DONE} seq_op_t;

    typedef struct packed {
        logic      rd_en;
        coef_sel_t rd_k;
        mul_op_t   mul;
        acc_op_t   acc;
        wr_op_t    wr;
        seq_op_t   seq;
    } ucode_t;

    // Control handed from the sequencer to the datapath
    typedef struct packed {
        ucode_t uc;
        logic   load;
    } dp_ctrl_t;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_GAIN  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_STAGE = 4'd3;
    localparam logic [STEP_W-1:0] STEP_OUT   = 4'd12;

    localparam ucode_t UC_IDLE = '{rd_en: 1'b0, rd_k: K_B0, mul: MUL_NONE,
                                   acc: ACC_NOP, wr: WR_NONE, seq: SEQ_DONE};

    function automatic ucode_t uw(input logic rd_en, input coef_sel_t rd_k,
                                  input mul_op_t mul, input acc_op_t acc,
                                  input wr_op_t wr, input seq_op_t seq);
        ucode_t w;
        w.rd_en = rd_en;
        w.rd_k  = rd_k;
        w.mul   = mul;
        w.acc   = acc;
        w.wr    = wr;
        w.seq   = seq;
        return w;
    endfunction

    // Microprogram: gain scaling, one pass per stage, result hand-off.
    // Memory read data and products are both registered.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            // gain * sample, round to a sample, skip stages if none active
            4'd0:  w = uw(1'b0, K_B0, MUL_GAIN_X, ACC_NOP,   WR_NONE, SEQ_NEXT);
            4'd1:  w = uw(1'b0, K_B0, MUL_NONE,   ACC_LD,    WR_NONE, SEQ_NEXT);
            4'd2:  w = uw(1'b0, K_B0, MUL_NONE,   ACC_NOP,   WR_X,    SEQ_SKIP_IF_EMPTY);
            // stage body: y = d1 + b0*x
            4'd3:  w = uw(1'b1, K_B0, MUL_NONE,   ACC_NOP,   WR_NONE, SEQ_NEXT);
            4'd4:  w = uw(1'b1, K_B1, MUL_COEF_X, ACC_NOP,   WR_NONE, SEQ_NEXT);
            4'd5:  w = uw(1'b1, K_A1, MUL_COEF_X, ACC_LD_D1, WR_NONE, SEQ_NEXT);
            // d1' = d2 + b1*x - a1*y
            4'd6:  w = uw(1'b0, K_A1, MUL_NONE,   ACC_LD_D2, WR_Y,    SEQ_NEXT);
            4'd7:  w = uw(1'b1, K_B2, MUL_COEF_Y, ACC_NOP,   WR_NONE, SEQ_NEXT);
            4'd8:  w = uw(1'b1, K_A2, MUL_COEF_X, ACC_SUB,   WR_NONE, SEQ_NEXT);
            // d2' = b2*x - a2*y
            4'd9:  w = uw(1'b0, K_A2, MUL_COEF_Y, ACC_LD,    WR_D1,   SEQ_NEXT);
            4'd10: w = uw(1'b0, K_A2, MUL_NONE,   ACC_SUB,   WR_NONE, SEQ_NEXT);
            4'd11: w = uw(1'b0, K_A2, MUL_NONE,   ACC_NOP,   WR_D2,   SEQ_LOOP);
            // result hand-off
            4'd12: w = UC_IDLE;
            default: w = UC_IDLE;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bqc_coef_mem.sv
// Coefficient memory: one write port, one registered read port
`default_nettype none

module bqc_coef_mem #(
    parameter int DEPTH  = 40,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic signed [DATA_W-1:0] wdata,
    input  wire logic                     re,
    input  wire logic [ADDR_W-1:0]        raddr,
    output logic signed [DATA_W-1:0]      rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    // Store a coefficient
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read on request, hold otherwise
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bqc_sequencer.sv
// Microcode sequencer: step counter, stage loop and coefficient addressing
`default_nettype none

module bqc_sequencer #(
    parameter int MAX_STAGES = 8,
    localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1,
    localparam int IW = $clog2(MAX_STAGES * bqc_pkg::COEFS_PER_STAGE)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bqc_pkg::STAGES_W-1:0]  stages_in_use,
    input  wire logic                          out_hold,
    output bqc_pkg::dp_ctrl_t                  dp_ctrl,
    output logic [SW-1:0]                      stage,
    output logic                               coef_re,
    output logic [IW-1:0]                      coef_raddr,
    output logic                               busy,
    output logic                               emit
);

    import bqc_pkg::*;

    localparam int NW    = $clog2(MAX_STAGES + 1);
    localparam int CMP_W = ((NW > STAGES_W) ? NW : STAGES_W) + 1;

    logic              run_reg, run_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SW-1:0]     stage_reg, stage_next;
    logic [IW-1:0]     base_reg, base_next;

    ucode_t           uc;
    logic [CMP_W-1:0] n_eff;
    logic [CMP_W-1:0] stage_plus1;
    logic             empty;

    // Fetch the current control word; idle word while stopped
    always_comb
    begin
        uc = run_reg ? ucode_rom(step_reg) : UC_IDLE;
    end

    // Active stage count, clamped to the built depth
    always_comb
    begin
        n_eff = (CMP_W'(stages_in_use) > CMP_W'(MAX_STAGES)) ? CMP_W'(MAX_STAGES)
                                                               : CMP_W'(stages_in_use);
        empty       = (n_eff == '0);
        stage_plus1 = CMP_W'(stage_reg) + CMP_W'(1);
    end

    // Next step, stage and coefficient base
    always_comb
    begin
        run_next   = run_reg;
        step_next  = step_reg;
        stage_next = stage_reg;
        base_next  = base_reg;
        if (start)
        begin
            run_next   = 1'b1;
            step_next  = STEP_GAIN;
            stage_next = '0;
            base_next  = '0;
        end
        else if (run_reg)
        begin
            unique case (uc.seq)
                SEQ_NEXT:
                begin
                    step_next = step_reg + STEP_W'(1);
                end
                SEQ_SKIP_IF_EMPTY:
                begin
                    step_next = empty ? STEP_OUT : step_reg + STEP_W'(1);
                end
                SEQ_LOOP:
                begin
                    if (stage_plus1 < n_eff)
                    begin
                        stage_next = stage_reg + SW'(1);
                        base_next  = base_reg + IW'(COEFS_PER_STAGE);
                        step_next  = STEP_STAGE;
                    end
                    else
                    begin
                        step_next = STEP_OUT;
                    end
                end
                SEQ_DONE:
                begin
                    if (!out_hold)
                    begin
                        run_next = 1'b0;
                    end
                end
                default:
                begin
                    run_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            step_reg  <= STEP_GAIN;
            stage_reg <= '0;
            base_reg  <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            step_reg  <= step_next;
            stage_reg <= stage_next;
            base_reg  <= base_next;
        end
    end

    // Outputs to datapath, memory and handshake logic
    always_comb
    begin
        dp_ctrl.uc   = uc;
        dp_ctrl.load = start;
        stage        = stage_reg;
        coef_re      = uc.rd_en;
        coef_raddr   = base_reg + IW'(uc.rd_k);
        busy         = run_reg;
        emit         = run_reg && (uc.seq == SEQ_DONE) && !out_hold;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bqc_datapath.sv
// Shared multiplier, accumulator, rounding and per-stage delay words
`default_nettype none

module bqc_datapath #(
    parameter int MAX_STAGES  = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16,
    localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bqc_pkg::dp_ctrl_t             dp_ctrl,
    input  wire logic [SW-1:0]                 stage,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire logic signed [COEF_BITS-1:0]   gain,
    input  wire logic signed [COEF_BITS-1:0]   coef_rd,
    output logic signed [SAMPLE_BITS-1:0]      result
);

    import bqc_pkg::*;

    localparam int PW   = SAMPLE_BITS + COEF_BITS;
    localparam int AW   = ((PW > STATE_BITS) ? PW : STATE_BITS) + 2;
    localparam int FRAC = COEF_BITS - 2;

    localparam logic signed [AW-1:0] RND_HALF = AW'(1) << (FRAC - 1);
    localparam logic signed [AW-1:0] S_MAX  = {{(AW - SAMPLE_BITS + 1){1'b0}},
                                               {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [AW-1:0] S_MIN  = ~S_MAX;
    localparam logic signed [AW-1:0] ST_MAX = {{(AW - STATE_BITS + 1){1'b0}},
                                               {(STATE_BITS - 1){1'b1}}};
    localparam logic signed [AW-1:0] ST_MIN = ~ST_MAX;

    logic signed [SAMPLE_BITS-1:0] x_reg, y_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [AW-1:0]          acc_reg;
    logic signed [STATE_BITS-1:0]  d1_reg [MAX_STAGES];
    logic signed [STATE_BITS-1:0]  d2_reg [MAX_STAGES];

    logic signed [PW-1:0]          mul_a, mul_b;
    logic signed [AW-1:0]          prod_ext, rnd, shr;
    logic signed [SAMPLE_BITS-1:0] acc_sample;
    logic signed [STATE_BITS-1:0]  acc_state;

    // Multiplier operand selection
    always_comb
    begin
        mul_a = (dp_ctrl.uc.mul == MUL_GAIN_X) ? PW'(gain) : PW'(coef_rd);
        mul_b = (dp_ctrl.uc.mul == MUL_COEF_Y) ? PW'(y_reg) : PW'(x_reg);
    end

    // Round half up to a sample, saturate; saturate to a delay word
    always_comb
    begin
        prod_ext = AW'(prod_reg);
        rnd      = acc_reg + RND_HALF;
        shr      = rnd >>> FRAC;
        if (shr > S_MAX)
        begin
            acc_sample = S_MAX[SAMPLE_BITS-1:0];
        end
        else if (shr < S_MIN)
        begin
            acc_sample = S_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            acc_sample = shr[SAMPLE_BITS-1:0];
        end
        if (acc_reg > ST_MAX)
        begin
            acc_state = ST_MAX[STATE_BITS-1:0];
        end
        else if (acc_reg < ST_MIN)
        begin
            acc_state = ST_MIN[STATE_BITS-1:0];
        end
        else
        begin
            acc_state = acc_reg[STATE_BITS-1:0];
        end
    end

    // Product register
    always_ff @(posedge clk)
    begin
        if (dp_ctrl.uc.mul != MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Accumulator
    always_ff @(posedge clk)
    begin
        unique case (dp_ctrl.uc.acc)
            ACC_NOP:   acc_reg <= acc_reg;
            ACC_LD_D1: acc_reg <= AW'(d1_reg[stage]) + prod_ext;
            ACC_LD_D2: acc_reg <= AW'(d2_reg[stage]) + prod_ext;
            ACC_LD:    acc_reg <= prod_ext;
            ACC_SUB:   acc_reg <= acc_reg - prod_ext;
            default:   acc_reg <= acc_reg;
        endcase
    end

    // Stage input: load sample, take scaled input, pass y to next stage
    always_ff @(posedge clk)
    begin
        if (dp_ctrl.load)
        begin
            x_reg <= sample_in;
        end
        else if (dp_ctrl.uc.wr == WR_X)
        begin
            x_reg <= acc_sample;
        end
        else if (dp_ctrl.uc.seq == SEQ_LOOP)
        begin
            x_reg <= y_reg;
        end
    end

    // Stage output
    always_ff @(posedge clk)
    begin
        if (dp_ctrl.uc.wr == WR_Y)
        begin
            y_reg <= acc_sample;
        end
    end

    // Delay words, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                d1_reg[i] <= '0;
                d2_reg[i] <= '0;
            end
        end
        else if (dp_ctrl.uc.wr == WR_D1)
        begin
            d1_reg[stage] <= acc_state;
        end
        else if (dp_ctrl.uc.wr == WR_D2)
        begin
            d2_reg[stage] <= acc_state;
        end
    end

    assign result = x_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/biquad_cascade_filter.sv
// Top level of the cascaded biquad filter
//
// Input stream (s_t*): tuser carries the item kind. Kind 0 filters the sample
// in tdata; kind 1 stores tdata's coefficient value at slot coef_index
// (stage*5 + k, k = b0, b1, b2, a1, a2); slots beyond the table are dropped.
// A coefficient transfer leaves the block idle and produces no output.
// Output stream (m_t*): one filtered sample per kind-0 transfer.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 gain, Q2.14;
// 1 active stage count); write only while no sample is in flight.
// After a sample transfer the program runs gain scaling, each active stage and the
// hand-off step; m_tvalid rises and s_tready returns in the same cycle, so the next
// sample is taken only when the last one is through. The nine steps per stage are
// set by the single shared multiplier and the registered coefficient memory port.
// A result waits in the output register; the next sample is taken meanwhile
// and its program stalls at the hand-off step until m_tready frees the register.
// Reset clears the delay words, sets gain to 1.0 and one active stage; the
// coefficient memory is not cleared and must be written before use.
`default_nettype none

module biquad_cascade_filter #(
    parameter int MAX_STAGES  = bqc_pkg::MAX_STAGES_DEF,
    parameter int SAMPLE_BITS = bqc_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bqc_pkg::COEF_BITS_DEF,
    localparam int IW    = $clog2(MAX_STAGES * bqc_pkg::COEFS_PER_STAGE),
    localparam int IN_W  = ((IW + COEF_BITS + SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // s_tdata: coef_index, coef_value, sample_in (from bit 0 up), zero pad
    input  wire logic [IN_W-1:0]                   s_tdata,
    // s_tuser: mode
    input  wire logic                              s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // m_tdata: sample_out, zero pad
    output logic [OUT_W-1:0]                       m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_we,
    input  wire logic [bqc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [COEF_BITS-1:0]              cfg_wdata
);

    import bqc_pkg::*;

    localparam int SW          = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int TABLE_DEPTH = MAX_STAGES * COEFS_PER_STAGE;
    localparam logic signed [COEF_BITS-1:0] GAIN_RESET = COEF_BITS'(1) << (COEF_BITS - 2);

    logic signed [COEF_BITS-1:0]   gain_reg;
    logic [STAGES_W-1:0]           stages_reg;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]              m_tdata_reg, m_tdata_next;

    logic [IW-1:0]                 in_idx;
    logic signed [COEF_BITS-1:0]   in_coef;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          in_xfer, start, coef_we;

    dp_ctrl_t                      dp_ctrl;
    logic [SW-1:0]                 stage;
    logic                          coef_re;
    logic [IW-1:0]                 coef_raddr;
    logic signed [COEF_BITS-1:0]   coef_rd;
    logic                          busy, emit, out_hold;
    logic signed [SAMPLE_BITS-1:0] result;

    // Unpack the input item
    always_comb
    begin
        in_idx    = s_tdata[IW-1:0];
        in_coef   = s_tdata[IW+COEF_BITS-1:IW];
        in_sample = s_tdata[IW+COEF_BITS+SAMPLE_BITS-1:IW+COEF_BITS];
    end

    // Input handshake: one item at a time
    always_comb
    begin
        s_tready = !busy;
        in_xfer  = s_tvalid && s_tready;
        start    = in_xfer && (s_tuser == MODE_FILTER);
        coef_we  = in_xfer && (s_tuser == MODE_COEF) && (int'(in_idx) < TABLE_DEPTH);
        out_hold = m_tvalid_reg && !m_tready;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            stages_reg <= STAGES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GAIN:   gain_reg   <= cfg_wdata;
                REG_STAGES: stages_reg <= cfg_wdata[STAGES_W-1:0];
                default:    gain_reg   <= gain_reg;
            endcase
        end
    end

    bqc_coef_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IW),
        .DATA_W (COEF_BITS)
    ) u_coef_mem (
        .clk   (clk),
        .we    (coef_we),
        .waddr (in_idx),
        .wdata (in_coef),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdata (coef_rd)
    );

    bqc_sequencer #(
        .MAX_STAGES (MAX_STAGES)
    ) u_sequencer (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .stages_in_use (stages_reg),
        .out_hold      (out_hold),
        .dp_ctrl       (dp_ctrl),
        .stage         (stage),
        .coef_re       (coef_re),
        .coef_raddr    (coef_raddr),
        .busy          (busy),
        .emit          (emit)
    );

    bqc_datapath #(
        .MAX_STAGES  (MAX_STAGES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_ctrl   (dp_ctrl),
        .stage     (stage),
        .sample_in (in_sample),
        .gain      (gain_reg),
        .coef_rd   (coef_rd),
        .result    (result)
    );

    // Output register: load on hand-off, drop on transfer
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'($unsigned(result));
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bqc_checker.sv
// Port-level checker for the biquad cascade, bound to the top level
`default_nettype none

`include "biquad_cascade_filter_macros.svh"

module bqc_checker #(
    parameter int OUT_W = 16
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             s_tuser,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    import bqc_pkg::*;

    // Hold a stalled result
    `BQC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A sample transfer starts the program and blocks further input
    `BQC_ASSERT_NEXT(a_sample_busy, clk, rst_n, s_tvalid && s_tready && (s_tuser == MODE_FILTER), !s_tready)

    // A coefficient transfer completes at once
    `BQC_ASSERT_NEXT(a_coef_quick, clk, rst_n, s_tvalid && s_tready && (s_tuser == MODE_COEF), s_tready)

    // A new result only appears at the end of a running program
    `BQC_ASSERT_NOW(a_out_from_run, clk, rst_n, $rose(m_tvalid), $past(!s_tready))

endmodule

bind biquad_cascade_filter bqc_checker #(
    .OUT_W (OUT_W)
) u_bqc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: bench/biquad_response_checker.sv
// Checker for the biquad cascade: predicts each filtered sample and compares it
`timescale 1ns / 100ps

module biquad_response_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending_count
);

    import bqc_pkg::*;

    localparam int COEF_FRAC   = COEF_BITS_DEF - 2;
    localparam int TABLE_SLOTS = MAX_STAGES_DEF * COEFS_PER_STAGE;
    // s_tdata layout: coef_index [5:0], coef_value [21:6], sample_in [37:22]
    localparam int IDX_LSB  = 0;
    localparam int CVAL_LSB = 6;
    localparam int SAMP_LSB = 22;

    logic signed [15:0] gain_q14;
    logic [3:0]         active_stages;
    logic signed [15:0] coef_slot [TABLE_SLOTS];
    logic signed [31:0] z1_word [MAX_STAGES_DEF];
    logic signed [31:0] z2_word [MAX_STAGES_DEF];

    logic [15:0] expected_samples [$];
    logic [15:0] want;
    logic [5:0]  slot_idx;
    int          mismatches;

    // Clamp a wide value to a signed field of the given width
    function automatic longint clamp_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Round half up, drop the fraction and clamp to a sample
    function automatic longint to_sample(input longint acc);
        return clamp_bits((acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC,
                          SAMPLE_BITS_DEF);
    endfunction

    // Scale one sample by the gain and run it through the active sections
    function automatic logic [15:0] cascade_response(input logic signed [15:0] sample);
        longint x;
        longint y;
        longint d1;
        longint d2;
        int     n;
        int     base;
        x = to_sample(longint'(sample) * longint'(gain_q14));
        n = (active_stages > MAX_STAGES_DEF) ? MAX_STAGES_DEF : int'(active_stages);
        for (int s = 0; s < n; s++)
        begin
            base = s * COEFS_PER_STAGE;
            y  = to_sample(longint'(z1_word[s]) + longint'(coef_slot[base + int'(K_B0)]) * x);
            d1 = longint'(z2_word[s]) - longint'(coef_slot[base + int'(K_A1)]) * y
                 + longint'(coef_slot[base + int'(K_B1)]) * x;
            d2 = longint'(coef_slot[base + int'(K_B2)]) * x
                 - longint'(coef_slot[base + int'(K_A2)]) * y;
            z1_word[s] = 32'(clamp_bits(d1, STATE_BITS));
            z2_word[s] = 32'(clamp_bits(d2, STATE_BITS));
            x = y;
        end
        return x[15:0];
    endfunction

    // Track configuration, retire output transfers, predict input transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_q14      = 16'sd16384;
            active_stages = STAGES_RESET;
            coef_slot     = '{default: '0};
            z1_word       = '{default: '0};
            z2_word       = '{default: '0};
            expected_samples.delete();
            mismatches    = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_GAIN)
                    gain_q14 = cfg_wdata;
                else
                    active_stages = cfg_wdata[3:0];
            end

            // Retire the oldest prediction first: it belongs to an earlier sample
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: output transfer with none expected, expected none, actual %0d",
                             $time, $signed(m_tdata));
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want)
                    begin
                        mismatches++;
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, $signed(want), $signed(m_tdata));
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser == MODE_COEF)
                begin
                    slot_idx = s_tdata[IDX_LSB +: 6];
                    // Drop writes beyond the table
                    if (slot_idx < TABLE_SLOTS)
                        coef_slot[slot_idx] = s_tdata[CVAL_LSB +: 16];
                end
                else
                    expected_samples.push_back(cascade_response(s_tdata[SAMP_LSB +: 16]));
            end

            fail_count    <= mismatches;
            pending_count <= expected_samples.size();
        end
    end

endmodule

FILE: bench/tb.sv
// Testbench top for the biquad cascade: stimulus, stalls, reset and verdict
`timescale 1ns / 100ps

module tb;

    import bqc_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int TABLE_SLOTS     = MAX_STAGES_DEF * COEFS_PER_STAGE;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 104;

    logic        clk;
    logic        rst_n;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int burst_left = 0;
    int ready_left = 0;

    logic [TABLE_SLOTS-1:0] slot_loaded = '0;

    logic [15:0] corner_samples [9] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
                                        16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000};
    int          fixed_gain   [6]   = '{16384, 32767, -32768, 0, 12000, -16384};
    int          fixed_stages [6]   = '{2, 8, 15, 1, 0, 9};

    biquad_cascade_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    biquad_response_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Stall the output side: short stalls, short ready runs, now and then a long free run
    always @(posedge clk)
    begin
        if (ready_left > 0)
            ready_left <= ready_left - 1;
        else
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    m_tready   <= 1'b1;
                    ready_left <= $urandom_range(100, 300);
                end
                1, 2, 3:
                begin
                    m_tready   <= 1'b0;
                    ready_left <= $urandom_range(1, 20);
                end
                default:
                begin
                    m_tready   <= 1'b1;
                    ready_left <= $urandom_range(0, 8);
                end
            endcase
        end
    end

    // Offer one item and hold it until the transfer; open a gap between bursts
    task automatic push_item(input logic mode, input logic [5:0] idx,
                             input logic [15:0] cval, input logic [15:0] samp);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                7:       gap = $urandom_range(13, 40);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, samp, cval, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (mode == MODE_COEF && idx < TABLE_SLOTS)
            slot_loaded[idx] = 1'b1;
    endtask

    task automatic push_sample(input logic [15:0] samp);
        push_item(MODE_FILTER, 6'($urandom), 16'($urandom), samp);
    endtask

    task automatic push_coef(input logic [5:0] idx, input logic [15:0] cval);
        push_item(MODE_COEF, idx, cval, 16'($urandom));
    endtask

    // Drop valid, wait for every outstanding sample, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0:       v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            1, 2:    v = int'($urandom);
            default: v = $urandom_range(0, 8000) - 4000;
        endcase
        return 16'(v);
    endfunction

    // Mostly well-behaved sections, some full-range and corner coefficients
    function automatic logic [15:0] pick_coef(input coef_sel_t k);
        int v;
        case ($urandom_range(0, 9))
            0:    v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            1, 2: v = int'($urandom);
            default:
            begin
                if (k == K_A2)
                    v = $urandom_range(0, 15900) - 3900;
                else if (k == K_A1)
                    v = $urandom_range(0, 24000) - 12000;
                else
                    v = $urandom_range(0, 16000) - 8000;
            end
        endcase
        return 16'(v);
    endfunction

    // Load every slot of the active sections that has not been written yet
    task automatic load_missing(input int stages);
        int eff;
        eff = (stages > MAX_STAGES_DEF) ? MAX_STAGES_DEF : stages;
        for (int i = 0; i < eff * COEFS_PER_STAGE; i++)
        begin
            if (!slot_loaded[i])
                push_coef(6'(i), pick_coef(coef_sel_t'(i % COEFS_PER_STAGE)));
        end
    endtask

    task automatic run_phase(input int gain, input int stages);
        int counted;
        int pick;
        wait_idle();
        write_reg(REG_GAIN, 16'(gain));
        write_reg(REG_STAGES, 16'(stages));
        load_missing(stages);
        counted = 0;
        while (counted < ITEMS_PER_PHASE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 84)
            begin
                push_sample(pick_sample());
                counted++;
            end
            else if (pick < 95)
            begin
                push_coef(6'($urandom_range(0, TABLE_SLOTS - 1)),
                          pick_coef(coef_sel_t'($urandom_range(0, COEFS_PER_STAGE - 1))));
                counted++;
            end
            else
                push_coef(6'($urandom_range(TABLE_SLOTS, 63)), 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = MODE_FILTER;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_GAIN;
        cfg_wdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner coefficients for the first section, then writes beyond the table
        push_coef(6'(int'(K_B0)), 16'h7FFF);
        push_coef(6'(int'(K_B1)), 16'h8000);
        push_coef(6'(int'(K_B2)), 16'h4000);
        push_coef(6'(int'(K_A1)), 16'h8000);
        push_coef(6'(int'(K_A2)), 16'h7FFF);
        push_coef(6'd40, 16'h1234);
        push_coef(6'd63, 16'hFFFF);

        // Full-scale samples drive the delay words into saturation
        foreach (corner_samples[i])
            push_sample(corner_samples[i]);

        // Rewrite a live coefficient between samples
        push_coef(6'(int'(K_B0)), 16'h0000);
        push_sample(16'd1000);

        // No active sections: scaled input passes straight through
        wait_idle();
        write_reg(REG_STAGES, 16'd0);
        write_reg(REG_GAIN, 16'h7FFF);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0001);
        push_sample(16'hFFFF);
        wait_idle();
        write_reg(REG_GAIN, 16'h8000);
        push_sample(16'h8000);
        push_sample(16'h7FFF);

        // Random phases: fixed corner settings first, then random ones
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 6)
                run_phase(fixed_gain[p], fixed_stages[p]);
            else if ($urandom_range(0, 1) != 0)
                run_phase($urandom_range(8000, 24000),
                          ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3)
                                                     : $urandom_range(0, 15));
            else
                run_phase(int'($signed(16'($urandom))), $urandom_range(0, 15));
        end

        wait_idle();
        if (fail_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

endmodule
